[src/plec_pkg.sv]
// ----------------------------------------------------------------------------
// plec_pkg: shared definitions for the positional list engine
// Sizes, field types, request and status codes, and the control word
// that the controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package plec_pkg;

  localparam int DEPTH  = 32;
  localparam int WIDTH  = 32;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int TYPE_W = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [WIDTH-1:0]  data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [TYPE_W-1:0] kind_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_POP_FRONT  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_ERASE      = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_FILL       = 3'd5,
    REQ_CLEAR      = 3'd6,
    REQ_ASSIGN     = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_POS   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE,
    CELL_COMPACT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     pos;
    idx_t     tail;
    logic     keep;
    data_t    val;
  } cell_ctl_t;

endpackage

[src/plec_if.sv]
// ----------------------------------------------------------------------------
// plec_req_if / plec_rsp_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface plec_req_if;
  logic                valid;
  logic                ready;
  plec_pkg::kind_t     req_type;
  plec_pkg::pos_t      position;
  plec_pkg::val_t      value;
  plec_pkg::pos_t      fill_count;

  modport source (output valid, req_type, position, value, fill_count, input ready);
  modport sink   (input valid, req_type, position, value, fill_count, output ready);
endinterface

interface plec_rsp_if;
  logic                valid;
  logic                ready;
  logic [plec_pkg::STAT_W-1:0] status;
  plec_pkg::pos_t      element_total;
  plec_pkg::val_t      last_value;
  logic                last_valid;

  modport source (output valid, status, element_total, last_value, last_valid,
                  input ready);
  modport sink   (input valid, status, element_total, last_value, last_valid,
                  output ready);
endinterface

[src/plec_cell.sv]
// ----------------------------------------------------------------------------
// plec_cell: one list position
// Holds one element and loads it from itself, a neighbor, the broadcast
// value or the list head, as the control word and its own index decide.
// ----------------------------------------------------------------------------
module plec_cell (
  input  logic                clk,
  input  plec_pkg::idx_t      idx,
  input  plec_pkg::cell_ctl_t ctl,
  input  plec_pkg::data_t     left_d,
  input  plec_pkg::data_t     right_d,
  input  plec_pkg::data_t     head,
  output plec_pkg::data_t     d
);

  plec_pkg::data_t d_next;

  always_comb begin
    d_next = d;
    unique case (ctl.op)
      plec_pkg::CELL_HOLD: d_next = d;
      plec_pkg::CELL_INSERT: begin
        if (idx == ctl.pos) begin
          d_next = ctl.val;
        end else if (idx > ctl.pos) begin
          d_next = left_d;
        end
      end
      plec_pkg::CELL_ERASE: begin
        if (idx >= ctl.pos) begin
          d_next = right_d;
        end
      end
      plec_pkg::CELL_WRITE: d_next = ctl.val;
      // The head leaves the front; a kept head is appended behind the
      // shrinking tail so that the kept elements keep their order.
      plec_pkg::CELL_COMPACT: begin
        if (ctl.keep && idx == ctl.tail) begin
          d_next = head;
        end else begin
          d_next = right_d;
        end
      end
      default: d_next = d;
    endcase
  end

  always_ff @(posedge clk) begin
    d <= d_next;
  end

endmodule

[src/plec_row.sv]
// ----------------------------------------------------------------------------
// plec_row: the chain of list cells
// Wires each cell to its neighbors and shares the head element with all.
// ----------------------------------------------------------------------------
module plec_row (
  input  logic                clk,
  input  plec_pkg::cell_ctl_t ctl,
  output plec_pkg::data_t     cells [plec_pkg::DEPTH]
);

  for (genvar i = 0; i < plec_pkg::DEPTH; i++) begin : g_cell
    plec_pkg::data_t left_d;
    plec_pkg::data_t right_d;

    // The end cells have no outer neighbor; they see their own element.
    if (i == 0) begin : g_first
      assign left_d = cells[i];
    end else begin : g_mid_l
      assign left_d = cells[i-1];
    end
    if (i == plec_pkg::DEPTH - 1) begin : g_last
      assign right_d = cells[i];
    end else begin : g_mid_r
      assign right_d = cells[i+1];
    end

    plec_cell u_cell (
      .clk     (clk),
      .idx     (plec_pkg::idx_t'(i)),
      .ctl     (ctl),
      .left_d  (left_d),
      .right_d (right_d),
      .head    (cells[0]),
      .d       (cells[i])
    );
  end

endmodule

[src/positional_list_engine_core.sv]
// A request beat is taken only in S_IDLE; it then passes through S_EXEC and
// S_DONE, where the result register is loaded once any earlier result is taken;
// remove_value on a non-empty list runs S_SCAN between them, where the compaction
// walks the list through the head cell once. One request is in flight at a time,
// so no new beat is taken until its result is loaded. Reset is synchronous: it
// empties the list and drops any pending result; the cell contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list with positional edits
// Controller and result register around a row of shifting list cells.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
  input  logic           clk,
  input  logic           rst,
  plec_req_if.sink       req,
  plec_rsp_if.source     rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t               state;
  plec_pkg::req_t       kind;
  plec_pkg::pos_t       position;
  plec_pkg::pos_t       fill_count;
  plec_pkg::data_t      val;
  plec_pkg::cnt_t       count;
  plec_pkg::cnt_t       len;
  plec_pkg::cnt_t       scan_left;
  plec_pkg::status_t    status;
  logic                 out_valid;

  plec_pkg::cell_ctl_t  ctl;
  plec_pkg::data_t      cells [plec_pkg::DEPTH];
  plec_pkg::status_t    exec_status;
  plec_pkg::cnt_t       exec_count;
  plec_pkg::cnt_t       len_next;
  plec_pkg::data_t      last_d;
  logic                 full;
  plec_pkg::cmp_t       pos_cmp;
  plec_pkg::cmp_t       cnt_cmp;

  assign full    = (count == plec_pkg::cnt_t'(plec_pkg::DEPTH));
  assign pos_cmp = plec_pkg::cmp_t'(position);
  assign cnt_cmp = plec_pkg::cmp_t'(count);
  assign last_d  = cells[plec_pkg::idx_t'(count - plec_pkg::cnt_t'(1))];
  assign len_next = ctl.keep ? len : len - plec_pkg::cnt_t'(1);

  always_comb begin
    ctl.op      = plec_pkg::CELL_HOLD;
    ctl.pos     = plec_pkg::idx_t'(position);
    ctl.tail    = plec_pkg::idx_t'(len - plec_pkg::cnt_t'(1));
    ctl.keep    = (cells[0] != val);
    ctl.val     = val;
    exec_status = plec_pkg::ST_OK;
    exec_count  = count;
    if (state == S_EXEC) begin
      unique case (kind)
        plec_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            exec_status = plec_pkg::ST_FULL;
          end else begin
            ctl.op     = plec_pkg::CELL_INSERT;
            ctl.pos    = '0;
            exec_count = count + plec_pkg::cnt_t'(1);
          end
        end
        plec_pkg::REQ_POP_FRONT: begin
          if (count == '0) begin
            exec_status = plec_pkg::ST_EMPTY;
          end else begin
            ctl.op     = plec_pkg::CELL_ERASE;
            ctl.pos    = '0;
            exec_count = count - plec_pkg::cnt_t'(1);
          end
        end
        plec_pkg::REQ_INSERT: begin
          if (pos_cmp > cnt_cmp) begin
            exec_status = plec_pkg::ST_POS;
          end else if (full) begin
            exec_status = plec_pkg::ST_FULL;
          end else begin
            ctl.op     = plec_pkg::CELL_INSERT;
            exec_count = count + plec_pkg::cnt_t'(1);
          end
        end
        plec_pkg::REQ_ERASE: begin
          if (pos_cmp >= cnt_cmp) begin
            exec_status = plec_pkg::ST_POS;
          end else begin
            ctl.op     = plec_pkg::CELL_ERASE;
            exec_count = count - plec_pkg::cnt_t'(1);
          end
        end
        plec_pkg::REQ_REMOVE: exec_count = count;
        plec_pkg::REQ_FILL:   ctl.op = plec_pkg::CELL_WRITE;
        plec_pkg::REQ_CLEAR:  exec_count = '0;
        plec_pkg::REQ_ASSIGN: begin
          if (plec_pkg::cmp_t'(fill_count) > plec_pkg::cmp_t'(plec_pkg::DEPTH)) begin
            exec_status = plec_pkg::ST_FULL;
          end else begin
            ctl.op     = plec_pkg::CELL_WRITE;
            exec_count = plec_pkg::cnt_t'(fill_count);
          end
        end
        default: exec_count = count;
      endcase
    end else if (state == S_SCAN) begin
      ctl.op = plec_pkg::CELL_COMPACT;
    end
  end

  plec_row u_row (
    .clk   (clk),
    .ctl   (ctl),
    .cells (cells)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind       <= plec_pkg::req_t'(req.req_type);
            position   <= req.position;
            fill_count <= req.fill_count;
            val        <= plec_pkg::data_t'(req.value);
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= exec_status;
          count  <= exec_count;
          if (kind == plec_pkg::REQ_REMOVE && count != '0) begin
            len       <= count;
            scan_left <= count;
            state     <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          len       <= len_next;
          scan_left <= scan_left - plec_pkg::cnt_t'(1);
          if (scan_left == plec_pkg::cnt_t'(1)) begin
            count <= len_next;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid         <= 1'b1;
            rsp.status        <= status;
            rsp.element_total <= plec_pkg::pos_t'(count);
            rsp.last_valid    <= (count != '0);
            rsp.last_value    <= (count != '0) ? plec_pkg::val_t'(last_d) : '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= plec_pkg::cnt_t'(plec_pkg::DEPTH))
    else $error("element count exceeds list capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.last_valid == (rsp.element_total != '0)))
    else $error("last_valid disagrees with element_total");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (len >= scan_left && scan_left != '0))
    else $error("compaction length fell below elements still to visit");

endmodule

[tb/sv/positional_list_engine_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb: self-checking bench for the list engine
// Feeds request beats through a short directed table and then a long random
// run. A local copy of the list predicts status, count and last element for
// every accepted request, and each result beat is checked in order.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
  import plec_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int PLAN_ROWS    = 26;

  typedef struct packed {
    status_t status;
    pos_t    total;
    val_t    last;
    logic    last_ok;
  } outcome_t;

  typedef struct packed {
    req_t     kind;
    pos_t     pos;
    val_t     val;
    pos_t     cnt;
    logic     typed;
    outcome_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  int   send_idle;
  int   rcv_idle;
  int   errors = 0;
  int   stall_cycles = 0;

  // Local image of the list, advanced at every accepted request beat.
  data_t       list_mem [DEPTH];
  int          list_len;
  outcome_t    outcome_q [$];

  plec_req_if req_if ();
  plec_rsp_if rsp_if ();

  positional_list_engine_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Rows with typed = 1 carry an expectation read straight off the rules;
  // the others are checked against the local list image.
  plan_row_t dir_plan [PLAN_ROWS] = '{
    '{REQ_POP_FRONT,  6'd0,  32'h0,        6'd0,  1'b1, '{ST_EMPTY, 6'd0,  32'h0,        1'b0}},
    '{REQ_ERASE,      6'd0,  32'h0,        6'd0,  1'b1, '{ST_POS,   6'd0,  32'h0,        1'b0}},
    '{REQ_ERASE,      6'd63, 32'h0,        6'd0,  1'b1, '{ST_POS,   6'd0,  32'h0,        1'b0}},
    '{REQ_INSERT,     6'd1,  32'h9,        6'd0,  1'b1, '{ST_POS,   6'd0,  32'h0,        1'b0}},
    '{REQ_FILL,       6'd0,  32'h5,        6'd0,  1'b1, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_CLEAR,      6'd0,  32'h0,        6'd0,  1'b1, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_REMOVE,     6'd0,  32'h0,        6'd0,  1'b1, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_ASSIGN,     6'd0,  32'h3,        6'd0,  1'b1, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_PUSH_FRONT, 6'd0,  32'hFFFFFFFF, 6'd0,  1'b1, '{ST_OK,    6'd1,  32'hFFFFFFFF, 1'b1}},
    '{REQ_INSERT,     6'd1,  32'h0,        6'd0,  1'b1, '{ST_OK,    6'd2,  32'h0,        1'b1}},
    '{REQ_INSERT,     6'd0,  32'h12345678, 6'd0,  1'b0, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_ERASE,      6'd3,  32'h0,        6'd0,  1'b0, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_ERASE,      6'd1,  32'h0,        6'd0,  1'b0, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_REMOVE,     6'd0,  32'h5,        6'd0,  1'b0, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_ASSIGN,     6'd0,  32'hA5A5A5A5, 6'd32, 1'b1, '{ST_OK,    6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_PUSH_FRONT, 6'd0,  32'h1,        6'd0,  1'b1, '{ST_FULL,  6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_INSERT,     6'd32, 32'h1,        6'd0,  1'b1, '{ST_FULL,  6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_INSERT,     6'd33, 32'h1,        6'd0,  1'b1, '{ST_POS,   6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_ASSIGN,     6'd0,  32'h2,        6'd33, 1'b1, '{ST_FULL,  6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_ASSIGN,     6'd0,  32'h2,        6'd63, 1'b1, '{ST_FULL,  6'd32, 32'hA5A5A5A5, 1'b1}},
    '{REQ_ERASE,      6'd31, 32'h0,        6'd0,  1'b1, '{ST_OK,    6'd31, 32'hA5A5A5A5, 1'b1}},
    '{REQ_INSERT,     6'd31, 32'h7,        6'd0,  1'b1, '{ST_OK,    6'd32, 32'h7,        1'b1}},
    '{REQ_POP_FRONT,  6'd0,  32'h0,        6'd0,  1'b0, '{ST_OK,    6'd0,  32'h0,        1'b0}},
    '{REQ_REMOVE,     6'd0,  32'hA5A5A5A5, 6'd0,  1'b1, '{ST_OK,    6'd1,  32'h7,        1'b1}},
    '{REQ_FILL,       6'd0,  32'hFFFFFFFF, 6'd0,  1'b1, '{ST_OK,    6'd1,  32'hFFFFFFFF, 1'b1}},
    '{REQ_CLEAR,      6'd0,  32'h0,        6'd0,  1'b1, '{ST_OK,    6'd0,  32'h0,        1'b0}}
  };

  function automatic outcome_t apply_list_request(req_t k, pos_t p, val_t v, pos_t f);
    outcome_t o;
    data_t    d;
    int       i;
    int       kept;
    d        = data_t'(v);
    o.status = ST_OK;
    case (k)
      REQ_PUSH_FRONT: begin
        if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = d;
          list_len++;
        end
      end
      REQ_POP_FRONT: begin
        if (list_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_INSERT: begin
        // Position is checked before fullness.
        if (int'(p) > list_len) begin
          o.status = ST_POS;
        end else if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(p); i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = d;
          list_len++;
        end
      end
      REQ_ERASE: begin
        if (int'(p) >= list_len) begin
          o.status = ST_POS;
        end else begin
          for (i = int'(p); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_REMOVE: begin
        kept = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] != d) begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        list_len = kept;
      end
      REQ_FILL: begin
        for (i = 0; i < list_len; i++) list_mem[i] = d;
      end
      REQ_CLEAR: begin
        list_len = 0;
      end
      default: begin
        if (int'(f) > DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = 0; i < int'(f); i++) list_mem[i] = d;
          list_len = int'(f);
        end
      end
    endcase
    o.total = pos_t'(list_len);
    if (list_len > 0) begin
      o.last    = val_t'(list_mem[list_len-1]);
      o.last_ok = 1'b1;
    end else begin
      o.last    = '0;
      o.last_ok = 1'b0;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Drives one request beat and books its expected result once it is taken.
  task automatic issue_request(req_t k, pos_t p, val_t v, pos_t f, logic typed,
                               outcome_t want);
    outcome_t predicted;
    if ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind_t'(k);
    req_if.position   <= p;
    req_if.value      <= v;
    req_if.fill_count <= f;
    do @(posedge clk); while (!req_if.ready);
    predicted = apply_list_request(k, p, v, f);
    outcome_q.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result beat", {30'd0, rsp_if.status}, 32'd0);
      end else begin
        want = outcome_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", {30'd0, rsp_if.status}, {30'd0, want.status});
        if (rsp_if.element_total !== want.total)
          report_mismatch("element_total", {26'd0, rsp_if.element_total}, {26'd0, want.total});
        if (rsp_if.last_value !== want.last)
          report_mismatch("last_value", rsp_if.last_value, want.last);
        if (rsp_if.last_valid !== want.last_ok)
          report_mismatch("last_valid", {31'd0, rsp_if.last_valid}, {31'd0, want.last_ok});
      end
    end
  end

  // Ends a hung run: counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[positional_list_engine_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    outcome_t none;
    req_t     k;
    pos_t     p;
    val_t     v;
    pos_t     f;
    int       r;
    int       n;
    none              = '0;
    list_len          = 0;
    send_idle         = 8;
    rcv_idle          = 47;
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= kind_t'(REQ_CLEAR);
    req_if.position   <= '0;
    req_if.value      <= '0;
    req_if.fill_count <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < PLAN_ROWS; n++) begin
      issue_request(dir_plan[n].kind, dir_plan[n].pos, dir_plan[n].val, dir_plan[n].cnt,
                    dir_plan[n].typed, dir_plan[n].want);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 47;
        rcv_idle  = 8;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        rcv_idle  = 0;
      end
      // Growing operations outweigh shrinking ones so the list often runs full.
      r = $urandom_range(99);
      if (r < 22)      k = REQ_PUSH_FRONT;
      else if (r < 34) k = REQ_POP_FRONT;
      else if (r < 56) k = REQ_INSERT;
      else if (r < 68) k = REQ_ERASE;
      else if (r < 76) k = REQ_REMOVE;
      else if (r < 83) k = REQ_FILL;
      else if (r < 87) k = REQ_CLEAR;
      else             k = REQ_ASSIGN;

      // A small value pool and copies of present elements make remove hit.
      r = $urandom_range(99);
      if (r < 35)                       v = val_t'($urandom_range(3));
      else if (r < 60 && list_len > 0)  v = val_t'(list_mem[$urandom_range(list_len - 1)]);
      else                              v = $urandom;

      p = pos_t'($urandom_range(63));
      if (k == REQ_INSERT && $urandom_range(99) < 85)
        p = pos_t'($urandom_range(list_len));
      else if (k == REQ_ERASE && list_len > 0 && $urandom_range(99) < 85)
        p = pos_t'($urandom_range(list_len - 1));

      r = $urandom_range(99);
      if (k != REQ_ASSIGN) f = pos_t'($urandom_range(63));
      else if (r < 10)     f = pos_t'(DEPTH);
      else if (r < 25)     f = pos_t'($urandom_range(63, DEPTH + 1));
      else                 f = pos_t'($urandom_range(DEPTH));

      issue_request(k, p, v, f, 1'b0, none);
    end
    req_if.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[positional_list_engine_core] OK");
    end else begin
      $display("[positional_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule
